/* hdl/ncc_pkg.sv */
// Shared constants, types and register codes for the nearest-centroid classifier.
package ncc_pkg;

  localparam int MAX_CLUSTERS = 32;
  localparam int MAX_DIM      = 64;
  localparam int FEATURE_BITS = 16;

  // field widths of the words on the ports
  localparam int FEAT_W         = FEATURE_BITS;
  localparam int CENTER_SLOT_W  = 5;
  localparam int FEATURE_SLOT_W = 6;
  localparam int DIST_W         = 48;
  localparam int NC_W           = 6;   // num_clusters register
  localparam int ND_W           = 7;   // num_dims register

  localparam int CL_IDX_W   = $clog2(MAX_CLUSTERS);
  localparam int DIM_IDX_W  = $clog2(MAX_DIM);
  localparam int CTR_ADDR_W = CL_IDX_W + DIM_IDX_W;
  localparam int SQ_W       = 2 * FEAT_W;

  // APB side
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [0:0] REG_NUM_CLUSTERS = 1'b0;
  localparam logic [0:0] REG_NUM_DIMS     = 1'b1;

  localparam logic [NC_W-1:0] NUM_CLUSTERS_RST = NC_W'(1);
  localparam logic [ND_W-1:0] NUM_DIMS_RST     = ND_W'(64);

  typedef struct packed {
    logic [NC_W-1:0] eff_clusters;   // 1..MAX_CLUSTERS
    logic [ND_W-1:0] eff_dims;       // 1..MAX_DIM
  } cfg_t;

  typedef struct packed {
    logic                  en;
    logic [CTR_ADDR_W-1:0] addr;
    logic [FEAT_W-1:0]     data;
  } ctr_wr_t;

  typedef struct packed {
    logic                en;
    logic [CL_IDX_W-1:0] addr;
    logic [DIST_W-1:0]   data;
  } sum_wr_t;

endpackage

/* hdl/ncc_cfg_regs.sv */
// APB register block: cluster and dimension counts, clamped for the engine.
module ncc_cfg_regs
  import ncc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic [NC_W-1:0] num_clusters_r;
  logic [ND_W-1:0] num_dims_r;
  logic            wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_clusters_r <= NUM_CLUSTERS_RST;
      num_dims_r     <= NUM_DIMS_RST;
    end else if (wr_en) begin
      case (paddr[2])
        REG_NUM_CLUSTERS: num_clusters_r <= pwdata[NC_W-1:0];
        REG_NUM_DIMS:     num_dims_r     <= pwdata[ND_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      case (paddr[2])
        REG_NUM_CLUSTERS: prdata = APB_DATA_W'(num_clusters_r);
        REG_NUM_DIMS:     prdata = APB_DATA_W'(num_dims_r);
        default:          prdata = '0;
      endcase
    end
  end

  // zero acts as one, large values saturate
  always_comb begin
    if (num_clusters_r == '0)
      cfg.eff_clusters = NC_W'(1);
    else if (num_clusters_r > NC_W'(MAX_CLUSTERS))
      cfg.eff_clusters = NC_W'(MAX_CLUSTERS);
    else
      cfg.eff_clusters = num_clusters_r;

    if (num_dims_r == '0)
      cfg.eff_dims = ND_W'(1);
    else if (num_dims_r > ND_W'(MAX_DIM))
      cfg.eff_dims = ND_W'(MAX_DIM);
    else
      cfg.eff_dims = num_dims_r;
  end

endmodule

/* hdl/ncc_center_mem.sv */
// Centroid element store: one write port, one registered read port.
module ncc_center_mem
  import ncc_pkg::*;
(
  input  logic                  clk,
  input  ctr_wr_t               wr,
  input  logic [CTR_ADDR_W-1:0] raddr,
  output logic [FEAT_W-1:0]     rdata
);

  logic [FEAT_W-1:0] mem [MAX_CLUSTERS*MAX_DIM];
  logic [FEAT_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hdl/ncc_sum_mem.sv */
// Per-cluster distance accumulators: one write port, one registered read port.
module ncc_sum_mem
  import ncc_pkg::*;
(
  input  logic                clk,
  input  sum_wr_t             wr,
  input  logic [CL_IDX_W-1:0] raddr,
  output logic [DIST_W-1:0]   rdata
);

  logic [DIST_W-1:0] mem [MAX_CLUSTERS];
  logic [DIST_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hdl/ncc_engine.sv */
// Sequencer and read-modify-write datapath over the centroid and sum stores.
module ncc_engine
  import ncc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  cfg_t                      cfg,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_mode,
  input  logic [CENTER_SLOT_W-1:0]  in_center_slot,
  input  logic [FEATURE_SLOT_W-1:0] in_feature_slot,
  input  logic signed [FEAT_W-1:0]  in_feature_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [CENTER_SLOT_W-1:0]  out_best_cluster,
  output logic [DIST_W-1:0]         out_best_distance,
  output ctr_wr_t                   ctr_wr,
  output logic [CTR_ADDR_W-1:0]     ctr_raddr,
  input  logic [FEAT_W-1:0]         ctr_rdata,
  output sum_wr_t                   sum_wr,
  output logic [CL_IDX_W-1:0]       sum_raddr,
  input  logic [DIST_W-1:0]         sum_rdata
);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FLUSH} state_t;

  state_t                    state_r;
  logic [CL_IDX_W-1:0]       k_r;
  logic [CL_IDX_W-1:0]       last_k_r;
  logic [DIM_IDX_W-1:0]      fslot_r;
  logic signed [FEAT_W-1:0]  value_r;
  logic                      final_r;
  logic                      out_valid_r;
  logic [CENTER_SLOT_W-1:0]  out_cluster_r;
  logic [DIST_W-1:0]         out_dist_r;

  logic                      p1_r, p2_r, p3_r;
  logic [CL_IDX_W-1:0]       k1_r, k2_r, k3_r;
  logic [MAX_CLUSTERS-1:0]   valid_r;
  logic [FEAT_W-1:0]         absd_r;
  logic [SQ_W-1:0]           sq_r;
  logic [DIST_W-1:0]         old1_r, old2_r;
  logic [DIST_W-1:0]         best_dist_r;
  logic [CL_IDX_W-1:0]       best_k_r;

  logic                      in_acc, load, query, in_range, pipe_busy, out_free, emit;
  logic signed [FEAT_W:0]    diff;
  logic [FEAT_W:0]           diff_mag;
  logic [DIST_W:0]           acc_sum;
  logic [DIST_W-1:0]         new_sum;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign in_range  = {1'b0, in_feature_slot} < cfg.eff_dims;
  assign load      = in_acc && !in_mode;
  assign query     = in_acc && in_mode && in_range;
  assign pipe_busy = p1_r || p2_r || p3_r;
  assign out_free  = !out_valid_r || out_ready;
  assign emit      = (state_r == ST_FLUSH) && !pipe_busy && final_r && out_free;

  // loads go straight into the store on the accept edge
  assign ctr_wr.en   = load;
  assign ctr_wr.addr = {in_center_slot[CL_IDX_W-1:0], in_feature_slot[DIM_IDX_W-1:0]};
  assign ctr_wr.data = in_feature_value;

  assign ctr_raddr = {k_r, fslot_r};
  assign sum_raddr = k_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (query) begin
            fslot_r  <= in_feature_slot[DIM_IDX_W-1:0];
            value_r  <= in_feature_value;
            final_r  <= ({1'b0, in_feature_slot} == cfg.eff_dims - 1'b1);
            last_k_r <= CL_IDX_W'(cfg.eff_clusters - 1'b1);
            k_r      <= '0;
            state_r  <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (k_r == last_k_r) begin
            state_r <= ST_FLUSH;
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        ST_FLUSH: begin
          if (!pipe_busy) begin
            if (!final_r) begin
              state_r <= ST_IDLE;
            end else if (out_free) begin
              out_cluster_r <= CENTER_SLOT_W'(best_k_r);
              out_dist_r    <= best_dist_r;
              state_r       <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_best_cluster  = out_cluster_r;
  assign out_best_distance = out_dist_r;

  // stage valids and accumulator valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_r    <= 1'b0;
      p2_r    <= 1'b0;
      p3_r    <= 1'b0;
      valid_r <= '0;
    end else begin
      p1_r <= (state_r == ST_RUN);
      p2_r <= p1_r;
      p3_r <= p2_r;
      if (query && in_feature_slot == '0) begin
        valid_r <= '0;
      end else if (p3_r) begin
        valid_r[k3_r] <= 1'b1;
      end
    end
  end

  // stage 1: difference magnitude; stage 2: square; stage 3: add and write back
  assign diff     = $signed({value_r[FEAT_W-1], value_r})
                  - $signed({ctr_rdata[FEAT_W-1], ctr_rdata});
  assign diff_mag = diff[FEAT_W] ? (FEAT_W+1)'(-diff) : diff;

  always_ff @(posedge clk) begin
    k1_r   <= k_r;
    absd_r <= diff_mag[FEAT_W-1:0];
    old1_r <= valid_r[k1_r] ? sum_rdata : '0;
    k2_r   <= k1_r;
    sq_r   <= absd_r * absd_r;
    old2_r <= old1_r;
    k3_r   <= k2_r;
  end

  assign acc_sum = {1'b0, old2_r} + (DIST_W+1)'(sq_r);
  assign new_sum = acc_sum[DIST_W] ? {DIST_W{1'b1}} : acc_sum[DIST_W-1:0];

  assign sum_wr.en   = p3_r;
  assign sum_wr.addr = k3_r;
  assign sum_wr.data = new_sum;

  // strict compare keeps the lower index on ties
  always_ff @(posedge clk) begin
    if (p3_r && (k3_r == '0 || new_sum < best_dist_r)) begin
      best_dist_r <= new_sum;
      best_k_r    <= k3_r;
    end
  end

`ifndef SYNTHESIS
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !pipe_busy)
    else $error("pipeline busy while accepting words");

  a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN |-> k_r <= last_k_r)
    else $error("cluster index beyond active count");

  a_stage_order: assert property (@(posedge clk) disable iff (!rst_n)
    p3_r && p2_r |-> k2_r == CL_IDX_W'(k3_r + 1'b1))
    else $error("accumulator write-back out of order");

  a_slot0_clear: assert property (@(posedge clk) disable iff (!rst_n)
    query && in_feature_slot == '0 |=> valid_r == '0)
    else $error("accumulators not cleared at slot zero");

  a_emit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FLUSH && !pipe_busy && final_r && out_free |=> out_valid_r)
    else $error("result not presented after last slot");
`endif

endmodule

/* hdl/nearest_centroid_classify_unit.sv */
// Top level of the nearest-centroid classifier (squared Euclidean distance).
//
//  channel | ports                                   | direction | word
//  --------+-----------------------------------------+-----------+--------------------------
//  in      | in_valid/in_ready + 4 payload ports     | sink      | load element or query feature
//  out     | out_valid/out_ready + 2 payload ports   | source    | nearest cluster, distance
//  cfg     | psel/penable/pwrite/paddr/pwdata/prdata | APB slave | num_clusters @0, num_dims @4
//
// A load word is written to the centroid store on its accept edge; the next
// word may follow in the next cycle.
// A query word holds in_ready low while the sequencer walks the
// active clusters one per cycle through the single read port of each store
// and the three-stage difference/square/accumulate pipe then drains.
// The last slot of a query loads the output register; a further last-slot
// query waits in its drain phase only while that register still holds a word.
// Synchronous active-low reset clears the accumulator valid bits (sums read
// as zero), control state and registers to num_clusters = 1, num_dims = 64.
module nearest_centroid_classify_unit
  import ncc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,

  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_mode,
  input  logic [CENTER_SLOT_W-1:0]  in_center_slot,
  input  logic [FEATURE_SLOT_W-1:0] in_feature_slot,
  input  logic signed [FEAT_W-1:0]  in_feature_value,

  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [CENTER_SLOT_W-1:0]  out_best_cluster,
  output logic [DIST_W-1:0]         out_best_distance,

  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [APB_ADDR_W-1:0]     paddr,
  input  logic [APB_DATA_W-1:0]     pwdata,
  output logic [APB_DATA_W-1:0]     prdata,
  output logic                      pready
);

  cfg_t                  cfg;
  ctr_wr_t               ctr_wr;
  logic [CTR_ADDR_W-1:0] ctr_raddr;
  logic [FEAT_W-1:0]     ctr_rdata;
  sum_wr_t               sum_wr;
  logic [CL_IDX_W-1:0]   sum_raddr;
  logic [DIST_W-1:0]     sum_rdata;

  // register block; counts are clamped here so the engine sees legal values
  ncc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // centroid elements, addressed {cluster, feature}
  ncc_center_mem u_center (
    .clk   (clk),
    .wr    (ctr_wr),
    .raddr (ctr_raddr),
    .rdata (ctr_rdata)
  );

  // running distance per cluster
  ncc_sum_mem u_sums (
    .clk   (clk),
    .wr    (sum_wr),
    .raddr (sum_raddr),
    .rdata (sum_rdata)
  );

  // sequencer, read-modify-write pipe, minimum tracking and output register
  ncc_engine u_engine (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_mode           (in_mode),
    .in_center_slot    (in_center_slot),
    .in_feature_slot   (in_feature_slot),
    .in_feature_value  (in_feature_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_best_cluster  (out_best_cluster),
    .out_best_distance (out_best_distance),
    .ctr_wr            (ctr_wr),
    .ctr_raddr         (ctr_raddr),
    .ctr_rdata         (ctr_rdata),
    .sum_wr            (sum_wr),
    .sum_raddr         (sum_raddr),
    .sum_rdata         (sum_rdata)
  );

endmodule

/* verif/ncc_tb_pkg.sv */
`timescale 1ns / 100ps
// Scoreboard class for the nearest-centroid classifier: own predictor plus expected-match queue.
package ncc_tb_pkg;
  import ncc_pkg::*;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam longint unsigned SUM_LIMIT = (64'd1 << DIST_W) - 64'd1;

  typedef struct packed {
    logic [CENTER_SLOT_W-1:0] cluster;
    logic [DIST_W-1:0]        distance;
  } match_t;

  class nearest_match_board;
    logic signed [FEAT_W-1:0] centre_mem [MAX_CLUSTERS][MAX_DIM];
    logic [DIST_W-1:0]        dist_acc [MAX_CLUSTERS];
    logic [NC_W-1:0]          clusters_reg;
    logic [ND_W-1:0]          dims_reg;
    match_t                   pending [$];
    int unsigned              results_seen;
    int unsigned              faults;

    function new();
      foreach (centre_mem[k, d]) centre_mem[k][d] = '0;
      foreach (dist_acc[k]) dist_acc[k] = '0;
      clusters_reg = NUM_CLUSTERS_RST;
      dims_reg     = NUM_DIMS_RST;
      results_seen = 0;
      faults       = 0;
    endfunction

    function int unsigned active_clusters();
      if (clusters_reg == 0) return 1;
      if (clusters_reg > MAX_CLUSTERS) return MAX_CLUSTERS;
      return clusters_reg;
    endfunction

    function int unsigned active_dims();
      if (dims_reg == 0) return 1;
      if (dims_reg > MAX_DIM) return MAX_DIM;
      return dims_reg;
    endfunction

    function void note_reg(logic [0:0] idx, int unsigned value);
      if (idx == REG_NUM_CLUSTERS) begin
        clusters_reg = NC_W'(value);
      end else begin
        dims_reg = ND_W'(value);
      end
    endfunction

    // one accepted input word; queues a match when it closes a query
    function void take_word(logic mode, logic [CENTER_SLOT_W-1:0] cslot,
                            logic [FEATURE_SLOT_W-1:0] fslot, logic signed [FEAT_W-1:0] val);
      int unsigned       nc, nd, k, best;
      longint            diff;
      longint unsigned   total;
      match_t            want;
      if (mode == MODE_LOAD) begin
        if (cslot < MAX_CLUSTERS && fslot < MAX_DIM) centre_mem[cslot][fslot] = val;
        return;
      end
      nd = active_dims();
      if (fslot >= nd) return;
      nc = active_clusters();
      if (fslot == 0) begin
        foreach (dist_acc[j]) dist_acc[j] = '0;
      end
      for (k = 0; k < nc; k++) begin
        diff = longint'(val) - longint'(centre_mem[k][fslot]);
        if (diff < 0) diff = -diff;
        total = longint'(dist_acc[k]) + longint'(diff * diff);
        if (total > SUM_LIMIT) total = SUM_LIMIT;
        dist_acc[k] = DIST_W'(total);
      end
      if (fslot != nd - 1) return;
      best = 0;
      for (k = 1; k < nc; k++) begin
        if (dist_acc[k] < dist_acc[best]) best = k;
      end
      want.cluster  = CENTER_SLOT_W'(best);
      want.distance = dist_acc[best];
      pending.insert(pending.size(), want);
    endfunction

    function void check_match(logic [CENTER_SLOT_W-1:0] cluster, logic [DIST_W-1:0] distance);
      match_t want;
      results_seen++;
      if (pending.size() == 0) begin
        faults++;
        if (faults <= 10)
          $display("unexpected result word: cluster %0d distance %0d", cluster, distance);
        return;
      end
      want = pending.pop_front();
      if (cluster !== want.cluster || distance !== want.distance) begin
        faults++;
        if (faults <= 10)
          $display("result %0d wrong: cluster exp %0d got %0d, distance exp %0d got %0d",
                   results_seen, want.cluster, cluster, want.distance, distance);
      end
    endfunction

    function bit clean();
      return faults == 0 && pending.size() == 0;
    endfunction
  endclass

endpackage

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// Testbench top for the nearest-centroid classifier: directed and random load/query traffic.
module tb_top;
  import ncc_pkg::*;
  import ncc_tb_pkg::*;

  // the longest query word walks all MAX_CLUSTERS clusters; allow a good margin on top
  localparam int DRAIN_CYCLES = MAX_CLUSTERS + 16;
  localparam int STALL_LIMIT  = 4000;
  localparam int WORD_TARGET  = 750;

  localparam logic signed [FEAT_W-1:0] VALUE_MIN = {1'b1, {(FEAT_W-1){1'b0}}};
  localparam logic signed [FEAT_W-1:0] VALUE_MAX = {1'b0, {(FEAT_W-1){1'b1}}};

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;

  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic                      in_mode = MODE_LOAD;
  logic [CENTER_SLOT_W-1:0]  in_center_slot = '0;
  logic [FEATURE_SLOT_W-1:0] in_feature_slot = '0;
  logic signed [FEAT_W-1:0]  in_feature_value = '0;

  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [CENTER_SLOT_W-1:0]  out_best_cluster;
  logic [DIST_W-1:0]         out_best_distance;

  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [APB_ADDR_W-1:0]     paddr = '0;
  logic [APB_DATA_W-1:0]     pwdata = '0;
  logic [APB_DATA_W-1:0]     prdata;
  logic                      pready;

  // idle odds in percent; moved through three bands as the run goes on
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  int unsigned words_sent = 0;
  int unsigned loads_sent = 0;
  int unsigned queries_sent = 0;
  int unsigned settings_run = 0;
  int unsigned quiet_cycles = 0;

  // centroid elements loaded so far; a query never reads one that is still clear
  bit centre_loaded [MAX_CLUSTERS][MAX_DIM];

  nearest_match_board board;

  nearest_centroid_classify_unit uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_center_slot   (in_center_slot),
    .in_feature_slot  (in_feature_slot),
    .in_feature_value (in_feature_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_best_cluster (out_best_cluster),
    .out_best_distance(out_best_distance),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // receiver: one ready decision per cycle, made on the falling edge
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Monitors and watchdog. Everything is sampled on the rising edge, so the
  // values seen are those set up on the previous falling edge. The result is
  // checked before the input word is noted so a stray result can never pair
  // with an expectation queued at the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) board.check_match(out_best_cluster, out_best_distance);
      if (in_valid && in_ready)
        board.take_word(in_mode, in_center_slot, in_feature_slot, in_feature_value);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("stalled for %0d cycles with %0d results outstanding",
                   quiet_cycles, board.pending.size());
          $display("FAIL");
          $finish;
        end
      end
    end
  end

  // Called on a falling edge; returns on the falling edge after acceptance
  // with valid still high, so a following word can go out back to back.
  // Anything else must park the sender first.
  task automatic send_word(input logic mode, input logic [CENTER_SLOT_W-1:0] cslot,
                           input logic [FEATURE_SLOT_W-1:0] fslot,
                           input logic signed [FEAT_W-1:0] val);
    if (words_sent < WORD_TARGET / 3) begin
      send_idle_pct = 32;
      recv_idle_pct = 88;
    end else if (words_sent < 2 * WORD_TARGET / 3) begin
      send_idle_pct = 88;
      recv_idle_pct = 32;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_mode          <= mode;
    in_center_slot   <= cslot;
    in_feature_slot  <= fslot;
    in_feature_value <= val;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic park_sender();
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic load_centre(input int unsigned centre, input int unsigned slot,
                             input logic signed [FEAT_W-1:0] val);
    send_word(MODE_LOAD, CENTER_SLOT_W'(centre), FEATURE_SLOT_W'(slot), val);
    centre_loaded[centre][slot] = 1'b1;
    loads_sent++;
  endtask

  task automatic query_feature(input int unsigned cslot, input int unsigned slot,
                               input logic signed [FEAT_W-1:0] val);
    send_word(MODE_QUERY, CENTER_SLOT_W'(cslot), FEATURE_SLOT_W'(slot), val);
    queries_sent++;
  endtask

  // hold the sender until every expected match is back, then let any
  // non-final query word still in the pipe run out
  task automatic drain();
    park_sender();
    while (board.pending.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // APB write: setup cycle, access cycle, register taken on the edge with pready
  task automatic write_reg(input logic [0:0] idx, input int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= APB_DATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    board.note_reg(idx, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // narrow values keep distances small and ties frequent
  function automatic logic signed [FEAT_W-1:0] pick_value(input bit narrow);
    int unsigned roll;
    roll = $urandom_range(7);
    if (narrow) return FEAT_W'(int'($urandom_range(6)) - 3);
    if (roll == 0) return VALUE_MIN;
    if (roll == 1) return VALUE_MAX;
    return FEAT_W'($urandom);
  endfunction

  // New register values, then load whatever part of the active centroid
  // block has never been written.
  task automatic set_config(input int unsigned nc_raw, input int unsigned nd_raw);
    int unsigned nc, nd, k, d;
    bit          narrow;
    drain();
    write_reg(REG_NUM_CLUSTERS, nc_raw);
    write_reg(REG_NUM_DIMS, nd_raw);
    settings_run++;
    nc = board.active_clusters();
    nd = board.active_dims();
    narrow = $urandom_range(1);
    for (k = 0; k < nc; k++) begin
      for (d = 0; d < nd; d++) begin
        if (!centre_loaded[k][d]) load_centre(k, d, pick_value(narrow));
      end
    end
  endtask

  // query features for slots first..last; values sit near a centroid, in a
  // narrow band or anywhere in range
  task automatic run_query(input int unsigned first, input int unsigned last);
    int unsigned              s, style, k;
    logic signed [FEAT_W-1:0] v;
    style = $urandom_range(2);
    for (s = first; s <= last; s++) begin
      k = $urandom_range(board.active_clusters() - 1);
      case (style)
        0:       v = FEAT_W'(int'(board.centre_mem[k][s]) + int'($urandom_range(2)) - 1);
        1:       v = pick_value(1'b1);
        default: v = pick_value(1'b0);
      endcase
      query_feature($urandom_range(MAX_CLUSTERS - 1), s, v);
    end
  endtask

  // mostly complete queries; the rest are interrupted by loads, padded with
  // ignored slots, started past slot zero or cut short
  task automatic random_phase(input int unsigned nc_raw, input int unsigned nd_raw);
    int unsigned nd, seqs, roll, cut;
    set_config(nc_raw, nd_raw);
    nd = board.active_dims();
    seqs = (nd >= 16) ? 2 : 4 + $urandom_range(6);
    repeat (seqs) begin
      roll = $urandom_range(99);
      cut  = $urandom_range(nd - 1);
      if (roll < 65) begin
        run_query(0, nd - 1);
      end else if (roll < 75) begin
        run_query(0, cut);
        load_centre($urandom_range(board.active_clusters() - 1), $urandom_range(nd - 1),
                    pick_value($urandom_range(1)));
        run_query(cut + 1, nd - 1);
      end else if (roll < 85) begin
        repeat ($urandom_range(1, 4)) begin
          if (nd < MAX_DIM && $urandom_range(1))
            query_feature($urandom_range(MAX_CLUSTERS - 1), $urandom_range(nd, MAX_DIM - 1),
                          pick_value(1'b0));
          else
            load_centre($urandom_range(MAX_CLUSTERS - 1), $urandom_range(MAX_DIM - 1),
                        pick_value(1'b0));
        end
      end else if (roll < 93) begin
        run_query(cut, nd - 1);
      end else begin
        run_query(0, cut);
      end
    end
  endtask

  initial begin
    int unsigned nc_raw, nd_raw;
    board = new();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: two centroids at opposite corners of the value range.
    load_centre(0, 0, VALUE_MIN);
    load_centre(0, 1, VALUE_MIN);
    load_centre(1, 0, VALUE_MAX);
    load_centre(1, 1, VALUE_MAX);
    set_config(2, 2);
    query_feature(0, 0, VALUE_MAX);             // exact hit on cluster 1
    query_feature(31, 1, VALUE_MAX);
    query_feature(31, 0, VALUE_MIN);            // exact hit on cluster 0
    query_feature(0, 1, VALUE_MIN);
    query_feature(0, 0, VALUE_MAX);             // equal distances, lower index wins,
    query_feature(0, 1, VALUE_MIN);             // largest squared terms
    query_feature(0, 1, 0);                     // no slot zero: sums carry on
    query_feature(31, 2, 0);                    // beyond the dimension count: ignored
    query_feature(31, 63, VALUE_MAX);
    set_config(1, 2);
    query_feature(0, 1, -1);                    // register write must leave sums alone

    // Register extremes, including zero and values past the maxima.
    random_phase(1, 64);
    random_phase(32, 1);
    random_phase(0, 0);
    random_phase(63, 3);
    random_phase(3, 127);

    // Random settings: large sizes only one axis at a time.
    while (words_sent < WORD_TARGET) begin
      case ($urandom_range(9))
        0: begin
          nc_raw = $urandom_range(63);
          nd_raw = $urandom_range(1, 4);
        end
        1: begin
          nc_raw = $urandom_range(3);
          nd_raw = $urandom_range(127);
        end
        default: begin
          nc_raw = $urandom_range(6);
          nd_raw = $urandom_range(8);
        end
      endcase
      random_phase(nc_raw, nd_raw);
    end

    drain();
    $display("Sent %0d words (%0d centroid loads, %0d query features) over %0d settings.",
             words_sent, loads_sent, queries_sent, settings_run);
    $display("Checked %0d nearest-centroid results; %0d faults, %0d still outstanding.",
             board.results_seen, board.faults, board.pending.size());
    if (board.clean()) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* nearest_centroid_classify_unit.f */
hdl/ncc_pkg.sv
hdl/ncc_cfg_regs.sv
hdl/ncc_center_mem.sv
hdl/ncc_sum_mem.sv
hdl/ncc_engine.sv
hdl/nearest_centroid_classify_unit.sv
verif/ncc_tb_pkg.sv
verif/tb_top.sv
